/* rtl/bal_pkg.sv */
package bal_pkg;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SORT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADIDX = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } out_t;

endpackage

/* rtl/bal_ram.sv */
module bal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/bal_ctrl.sv */
module bal_ctrl #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  bal_pkg::in_t     in_data,
  input  logic [CW-1:0]    cap_eff,
  output logic             out_valid,
  output bal_pkg::out_t    out_data,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [WIDTH-1:0] ram_wdata,
  output logic             ram_re,
  output logic [AW-1:0]    ram_raddr,
  input  logic [WIDTH-1:0] ram_rdata
);

  import bal_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_INS, S_DEL, S_FIND, S_SORT} state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    stop_r, stop_nxt;
  logic             iss_r, iss_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pidx_r, pidx_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [WIDTH-1:0] word_r, word_nxt;
  logic [WIDTH-1:0] max_r, max_nxt;
  logic             swap_r, swap_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic [WIDTH-1:0] in_word;
  logic             full;
  logic             accept;

  assign in_word = WIDTH'(in_data.value);
  assign full    = (used_r >= cap_eff);
  assign busy    = (state_r != S_IDLE);
  assign accept  = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    stop_nxt      = stop_r;
    iss_nxt       = iss_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    max_nxt       = max_r;
    swap_nxt      = swap_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = pidx_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;

    // Scan engine: one read per cycle, the returned word is used in the cycle after its read.
    if (state_r != S_IDLE) begin
      pend_nxt = iss_r;
      pidx_nxt = idx_r;
      if (iss_r) begin
        ram_re = 1'b1;
        if (idx_r == stop_r) begin
          iss_nxt = 1'b0;
        end else if (state_r == S_INS) begin
          idx_nxt = idx_r - 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_data_nxt.status = ST_OK;
          out_data_nxt.found  = 1'b0;
          case (in_data.cmd)
            CMD_APPEND: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(used_r);
                ram_wdata = in_word;
                used_nxt  = used_r + 1'b1;
              end
            end
            CMD_INSERT: begin
              if (full) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_FULL;
              end else if (32'(in_data.position) > 32'(used_r)) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_BADIDX;
              end else if (32'(in_data.position) == 32'(used_r)) begin
                out_valid_nxt = 1'b1;
                ram_we        = 1'b1;
                ram_waddr     = AW'(used_r);
                ram_wdata     = in_word;
                used_nxt      = used_r + 1'b1;
              end else begin
                pos_nxt   = AW'(in_data.position);
                word_nxt  = in_word;
                idx_nxt   = AW'(used_r - 1'b1);
                stop_nxt  = AW'(in_data.position);
                iss_nxt   = 1'b1;
                state_nxt = S_INS;
              end
            end
            CMD_DELETE: begin
              if (32'(in_data.position) >= 32'(used_r)) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_BADIDX;
              end else if (32'(in_data.position) + 32'd1 == 32'(used_r)) begin
                out_valid_nxt = 1'b1;
                used_nxt      = used_r - 1'b1;
              end else begin
                idx_nxt   = AW'(in_data.position) + 1'b1;
                stop_nxt  = AW'(used_r - 1'b1);
                iss_nxt   = 1'b1;
                state_nxt = S_DEL;
              end
            end
            CMD_SORT: begin
              if (used_r < CW'(2)) begin
                out_valid_nxt = 1'b1;
              end else begin
                idx_nxt   = '0;
                stop_nxt  = AW'(used_r - 1'b1);
                swap_nxt  = 1'b0;
                iss_nxt   = 1'b1;
                state_nxt = S_SORT;
              end
            end
            CMD_FIND: begin
              if (used_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                word_nxt  = in_word;
                found_nxt = 1'b0;
                idx_nxt   = '0;
                stop_nxt  = AW'(used_r - 1'b1);
                iss_nxt   = 1'b1;
                state_nxt = S_FIND;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_INS: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_r + 1'b1;
          ram_wdata = ram_rdata;
        end else if (!iss_r) begin
          ram_we              = 1'b1;
          ram_waddr           = pos_r;
          ram_wdata           = word_r;
          used_nxt            = used_r + 1'b1;
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = ST_OK;
          out_data_nxt.found  = 1'b0;
          state_nxt           = S_IDLE;
        end
      end
      S_DEL: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_r - 1'b1;
          ram_wdata = ram_rdata;
        end else if (!iss_r) begin
          used_nxt            = used_r - 1'b1;
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = ST_OK;
          out_data_nxt.found  = 1'b0;
          state_nxt           = S_IDLE;
        end
      end
      S_FIND: begin
        if (pend_r) begin
          if (ram_rdata == word_r) begin
            found_nxt = 1'b1;
          end
        end else if (!iss_r) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = ST_OK;
          out_data_nxt.found  = found_r;
          state_nxt           = S_IDLE;
        end
      end
      S_SORT: begin
        // Bubble pass: the larger word rides along in max_r, the smaller one
        // is written back one place lower.
        if (pend_r) begin
          if (pidx_r == '0) begin
            max_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = pidx_r - 1'b1;
            if ($signed(max_r) > $signed(ram_rdata)) begin
              ram_wdata = ram_rdata;
              swap_nxt  = 1'b1;
            end else begin
              ram_wdata = max_r;
              max_nxt   = ram_rdata;
            end
          end
        end else if (!iss_r) begin
          ram_we    = 1'b1;
          ram_waddr = stop_r;
          ram_wdata = max_r;
          if (stop_r == AW'(1) || !swap_r) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_OK;
            out_data_nxt.found  = 1'b0;
            state_nxt           = S_IDLE;
          end else begin
            stop_nxt = stop_r - 1'b1;
            idx_nxt  = '0;
            swap_nxt = 1'b0;
            iss_nxt  = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_valid_nxt) begin
      out_data_nxt.count = COUNT_W'(used_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      iss_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    stop_r     <= stop_nxt;
    pidx_r     <= pidx_nxt;
    pos_r      <= pos_nxt;
    word_r     <= word_nxt;
    max_r      <= max_nxt;
    swap_r     <= swap_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(DEPTH))
    else $error("entry count exceeds the list depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("read and write to the same entry in one cycle");

  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    used_r != $past(used_r) |-> out_valid_r)
    else $error("entry count changed without a result word");

  a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r || state_r != S_IDLE)
    else $error("accepted command neither finished nor started work");

endmodule

/* rtl/bounded_array_list.sv */
// Bounded ordered list of signed words kept in one single-port-write,
// registered-read RAM. A command is taken when start is high and busy is
// low; its result word appears on out_data with out_valid high for exactly
// one cycle and cannot be held off. Append, insert at the end of the list,
// rejected commands and trivial cases (delete of the last entry, sort of fewer
// than two entries, find on an empty list, unknown codes) keep busy low and
// give their result in the cycle after the command. Other commands hold busy
// high while they work through the RAM. Insert at a position p below used
// moves the entries from used - 1 down to p one place up and then writes the
// new word at p; delete at p moves the entries above p one place down; one
// entry is moved per cycle through the RAM. Find reads every entry once and
// compares it. Sort is a bubble sort over the RAM: each pass walks the first
// k entries, passes shrink by one and stop early once a pass makes no swap,
// so a sorted list costs one pass. The single RAM read and write port sets
// the pace of all of these. busy drops in the cycle the result is shown, so
// a new command may start then. The capacity register (reset 16, taken as
// DEPTH when above it) is written through cfg_valid/cfg_ready while the
// block is idle and no command is offered.
module bounded_array_list #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  bal_pkg::in_t          in_data,
  output logic                  out_valid,
  output bal_pkg::out_t         out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [bal_pkg::CAP_W-1:0] cfg_data
);

  import bal_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    cap_eff;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WIDTH-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [WIDTH-1:0] ram_rdata;

  // A capacity word is never taken at the edge that takes a command.
  assign cfg_ready = !busy && !start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // A capacity above the RAM depth is treated as the depth.
  assign cap_eff = (32'(cap_r) > DEPTH) ? CW'(DEPTH) : CW'(cap_r);

  bal_ctrl #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cap_eff   (cap_eff),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bal_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* bench/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bal_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 204;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  bounded_array_list DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Commands waiting to be sent and result words still owed by the block.
  in_t pending_cmds[$];
  out_t expected_results[$];

  // Predicted list contents.
  logic signed [VALUE_W-1:0] list_words[LIST_DEPTH];
  int list_len = 0;
  int cap_eff = LIST_DEPTH;

  // Stimulus-side view of the list length, used to aim positions and to steer between filling and draining.
  int gen_len = 0;
  int gen_cap = LIST_DEPTH;
  bit filling = 1'b1;
  logic signed [VALUE_W-1:0] recent_words[8];

  int idle_pct = 0;
  int gap_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int cmd_hits[8];
  int full_seen = 0;
  int badidx_seen = 0;
  int found_seen = 0;
  int cfg_writes = 0;

  task automatic list_apply(input in_t c, output out_t r);
    int k;
    int j;
    logic signed [VALUE_W-1:0] key;
    r = '0;
    r.status = ST_OK;
    case (c.cmd)
      CMD_APPEND: begin
        if (list_len >= cap_eff) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_len] = c.value;
          list_len++;
        end
      end
      CMD_INSERT: begin
        if (list_len >= cap_eff) begin
          r.status = ST_FULL;
        end else if (c.position > list_len) begin
          r.status = ST_BADIDX;
        end else begin
          for (k = list_len; k > c.position; k--) list_words[k] = list_words[k-1];
          list_words[c.position] = c.value;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (c.position >= list_len) begin
          r.status = ST_BADIDX;
        end else begin
          for (k = c.position; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
        end
      end
      CMD_SORT: begin
        for (k = 1; k < list_len; k++) begin
          key = list_words[k];
          j = k;
          while (j > 0 && list_words[j-1] > key) begin
            list_words[j] = list_words[j-1];
            j--;
          end
          list_words[j] = key;
        end
      end
      CMD_FIND: begin
        for (k = 0; k < list_len; k++) begin
          if (list_words[k] == c.value) r.found = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(list_len);
  endtask

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // Driver: once start is raised it stays up until the command is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        start <= 1'b1;
        in_data <= pending_cmds.pop_front();
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) gap_left <= $urandom_range(1, 18);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: the result of an older command is retired before a command
  // taken at the same edge is predicted.
  always @(posedge clk) begin : result_check
    out_t want;
    out_t pred;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual %p", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("found", want.found, out_data.found);
          check_field("count", want.count, out_data.count);
        end
      end
      if (start && !busy) begin
        list_apply(in_data, pred);
        expected_results.push_back(pred);
        cmd_hits[in_data.cmd]++;
        if (pred.status == ST_FULL) full_seen++;
        if (pred.status == ST_BADIDX) badidx_seen++;
        if (pred.found) found_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] op, input int pos,
                           input logic signed [VALUE_W-1:0] word);
    in_t c;
    c.cmd = op;
    c.position = POS_W'(pos);
    c.value = word;
    pending_cmds.push_back(c);
    case (op)
      CMD_APPEND: begin
        if (gen_len < gen_cap) gen_len++;
        recent_words[$urandom_range(7)] = word;
      end
      CMD_INSERT: begin
        if (gen_len < gen_cap && c.position <= gen_len) gen_len++;
        recent_words[$urandom_range(7)] = word;
      end
      CMD_DELETE: if (c.position < gen_len) gen_len--;
      default: begin
      end
    endcase
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_word();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1: return int'($urandom_range(16)) - 8;
      2: return recent_words[$urandom_range(7)];
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_cmd();
    logic [CMD_W-1:0] op;
    int pos;
    int r;
    if (gen_cap > 0 && gen_len >= gen_cap) filling = 1'b0;
    if (gen_len == 0) filling = 1'b1;
    if ($urandom_range(99) < 3) filling = !filling;
    r = $urandom_range(99);
    if (filling) begin
      op = r < 35 ? CMD_APPEND : r < 60 ? CMD_INSERT : r < 70 ? CMD_DELETE :
           r < 80 ? CMD_SORT : r < 95 ? CMD_FIND : CMD_W'($urandom_range(5, 7));
    end else begin
      op = r < 10 ? CMD_APPEND : r < 20 ? CMD_INSERT : r < 65 ? CMD_DELETE :
           r < 75 ? CMD_SORT : r < 95 ? CMD_FIND : CMD_W'($urandom_range(5, 7));
    end
    // Mostly legal positions, with an occasional one anywhere in the field.
    if ($urandom_range(7) == 0) pos = $urandom_range(31);
    else if (op == CMD_INSERT) pos = $urandom_range(gen_len);
    else if (gen_len > 0) pos = $urandom_range(gen_len - 1);
    else pos = 0;
    queue_cmd(op, pos, pick_word());
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_data <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_eff = (cap > LIST_DEPTH) ? LIST_DEPTH : int'(cap);
    gen_cap = cap_eff;
    cfg_writes++;
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] caps[9];
    int pcts[9];
    int p;
    int n;
    caps = '{5'd16, 5'd7, 5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd12, 5'd16};
    pcts = '{30, 50, 0, 30, 60, 20, 40, 25, 0};
    foreach (recent_words[i]) recent_words[i] = $urandom;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty-list cases, edge values, position limits,
    // unknown codes.
    idle_pct = 20;
    queue_cmd(CMD_DELETE, 0, 0);
    queue_cmd(CMD_FIND, 0, 0);
    queue_cmd(CMD_SORT, 0, 0);
    queue_cmd(CMD_INSERT, 1, 5);
    queue_cmd(CMD_INSERT, 0, 32'sh8000_0000);
    queue_cmd(CMD_APPEND, 0, 32'sh7fff_ffff);
    queue_cmd(CMD_APPEND, 31, 0);
    queue_cmd(CMD_APPEND, 0, -1);
    queue_cmd(CMD_INSERT, 2, 1);
    queue_cmd(CMD_INSERT, 5, 32'sh5555_5555);
    queue_cmd(CMD_INSERT, 16, 3);
    queue_cmd(CMD_INSERT, 31, 3);
    queue_cmd(CMD_FIND, 0, 32'sh7fff_ffff);
    queue_cmd(CMD_FIND, 0, 12345);
    queue_cmd(CMD_SORT, 0, 0);
    queue_cmd(CMD_FIND, 0, 32'sh8000_0000);
    queue_cmd(CMD_DELETE, 0, 0);
    queue_cmd(CMD_DELETE, 4, 0);
    queue_cmd(CMD_DELETE, 31, 0);
    queue_cmd(CMD_DELETE, 4, 0);
    queue_cmd(3'd5, 31, -1);
    queue_cmd(3'd6, 0, 0);
    queue_cmd(3'd7, 10, 32'sh2aaa_aaaa);
    queue_cmd(CMD_SORT, 0, 0);

    // Random part: one capacity setting per phase, written while idle.
    for (p = 0; p < 9; p++) begin
      wait_drained();
      write_capacity(caps[p]);
      idle_pct = pcts[p];
      for (n = 0; n < PHASE_ITEMS; n++) queue_random_cmd();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Ran %0d commands: %0d append, %0d insert, %0d delete, %0d sort, %0d find,",
             cmd_hits[0] + cmd_hits[1] + cmd_hits[2] + cmd_hits[3] + cmd_hits[4] +
             cmd_hits[5] + cmd_hits[6] + cmd_hits[7], cmd_hits[0], cmd_hits[1],
             cmd_hits[2], cmd_hits[3], cmd_hits[4]);
    $display("%0d unknown; %0d full, %0d bad index, %0d found; %0d capacity writes.",
             cmd_hits[5] + cmd_hits[6] + cmd_hits[7], full_seen, badidx_seen,
             found_seen, cfg_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* bounded_array_list.f */
rtl/bal_pkg.sv
rtl/bal_ram.sv
rtl/bal_ctrl.sv
rtl/bounded_array_list.sv
bench/tb_top.sv
